// ===== hw/rtl/vau_pkg.sv =====
`default_nettype none

package vau_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;
   localparam int SQLEN_WIDTH     = 2 * COORD_WIDTH + 2;
   localparam int SHIFT_WIDTH     = $clog2(COORD_WIDTH + 1);
   localparam int MAG_EXT_WIDTH   = (COORD_WIDTH > 30) ? COORD_WIDTH : 30;

   localparam int ROOT_STEPS   = 62;
   localparam int DIV_STEPS    = 30;
   localparam int ROOT2_STEPS  = 31;
   localparam int HORNER_STEPS = 7;

   localparam logic [47:0] NORM_LIMIT = 48'h0000_4000_0000;
   localparam logic [30:0] Q_ONE      = 31'h4000_0000;
   localparam logic [32:0] PI_Q       = 33'd3373259426;
   localparam logic [32:0] HALF_PI_Q  = 33'd1686629713;
   localparam logic [32:0] TWO_PI_Q   = 33'd6746518852;

   localparam int          ROUND_SHIFT = 30 - ANGLE_FRAC_BITS;
   localparam logic [33:0] ROUND_BIAS  = 34'd1 << (29 - ANGLE_FRAC_BITS);
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_MAX =
      ANGLE_WIDTH'(({1'b0, TWO_PI_Q} + ROUND_BIAS) >> ROUND_SHIFT);

   localparam logic [1:0] FUNC_ACUTE = 2'd1;
   localparam logic [1:0] FUNC_FULL  = 2'd2;

   typedef struct packed {
      logic [123:0] rad;
      logic [65:0]  rem;
      logic [61:0]  root;
   } sqrt_type;

   function automatic logic signed [35:0] acos_coef(input logic [2:0] idx);
      logic signed [35:0] c;
      case (idx)
         3'd0: c = 36'sd1686629690;
         3'd1: c = -36'sd230423709;
         3'd2: c = 36'sd95540460;
         3'd3: c = -36'sd53874250;
         3'd4: c = 36'sd33169905;
         3'd5: c = -36'sd18348235;
         3'd6: c = 36'sd7161955;
         3'd7: c = -36'sd1355590;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vau_sqrt_step.sv =====
`default_nettype none

module vau_sqrt_step (
   input  vau_pkg::sqrt_type cur_i,
   output vau_pkg::sqrt_type nxt_o
);
   import vau_pkg::*;

   logic [65:0] rem2;
   logic [65:0] trial;

   always_comb begin
      rem2  = {cur_i.rem[63:0], cur_i.rad[123:122]};
      trial = {2'b00, cur_i.root, 2'b01};
      nxt_o.rad = {cur_i.rad[121:0], 2'b00};
      if (rem2 >= trial) begin
         nxt_o.rem  = rem2 - trial;
         nxt_o.root = {cur_i.root[60:0], 1'b1};
      end else begin
         nxt_o.rem  = rem2;
         nxt_o.root = {cur_i.root[60:0], 1'b0};
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vector_angle_unit.sv =====
// channel | ports                          | direction | transaction
// req     | req_valid req_stall req_*      | in        | func and three vectors
// rsp     | rsp_valid rsp_stall rsp_*      | out       | angle and zero flag
// csr     | csr_valid csr_ready csr_data   | in        | zero length limit write
//
// one transaction per cycle sustained while the result is not stalled
// the pipeline holds two bit-serial square roots and a radix-2 divider, one step per stage
// reset clears all stage valid bits and the limit register
// a stalled result freezes the whole pipeline, nothing is lost or repeated
`default_nettype none

module vector_angle_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_func,
   input  logic signed [vau_pkg::COORD_WIDTH-1:0]   req_ax,
   input  logic signed [vau_pkg::COORD_WIDTH-1:0]   req_ay,
   input  logic signed [vau_pkg::COORD_WIDTH-1:0]   req_az,
   input  logic signed [vau_pkg::COORD_WIDTH-1:0]   req_bx,
   input  logic signed [vau_pkg::COORD_WIDTH-1:0]   req_by_coord,
   input  logic signed [vau_pkg::COORD_WIDTH-1:0]   req_bz,
   input  logic signed [vau_pkg::COORD_WIDTH-1:0]   req_nx,
   input  logic signed [vau_pkg::COORD_WIDTH-1:0]   req_ny,
   input  logic signed [vau_pkg::COORD_WIDTH-1:0]   req_nz,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [vau_pkg::ANGLE_WIDTH-1:0]          rsp_angle,
   output logic                                     rsp_zero_vector,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [31:0]                              csr_data
);
   import vau_pkg::*;

   typedef struct packed {
      logic                         valid;
      logic [1:0]                   func;
      logic [8:0]                   neg;
      logic [8:0][COORD_WIDTH-1:0]  mag;
   } s1_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       func;
      logic             zero;
      logic [8:0][30:0] pre;
   } s2_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         func;
      logic               zero;
      logic signed [63:0] d;
      logic [61:0]        la;
      logic [61:0]        lb;
      logic [2:0][30:0]   n;
      logic [2:0][62:0]   cr;
   } s3_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       func;
      logic             zero;
      logic             dneg;
      logic [62:0]      dmag;
      logic [3:0][61:0] pp;
      logic [2:0][62:0] tph;
      logic [2:0][62:0] tpl;
   } s4_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         func;
      logic               zero;
      logic               flip;
      logic               dneg;
      logic [62:0]        dmag;
      logic [61:0]        sval;
      logic               sat;
      logic [63:0]        drem;
      logic [29:0]        quo;
      logic [30:0]        xval;
      logic signed [35:0] poly;
   } side_type;

   typedef struct packed {
      side_type side;
      sqrt_type sq;
   } root_stage_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  func;
      logic        zero;
      logic        flip;
      logic        dneg;
      logic [35:0] theta;
   } hh_type;

   typedef struct packed {
      logic                   valid;
      logic [ANGLE_WIDTH-1:0] angle;
      logic                   zero;
   } out_type;

   logic        adv;
   logic [31:0] limit_ff;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   hh_type hh_ff, hh_in;
   out_type out_ff, out_in;

   root_stage_type root_ff [0:ROOT_STEPS];
   root_stage_type root_in;
   sqrt_type       root_nxt [0:ROOT_STEPS-1];

   side_type dv_ff [0:DIV_STEPS];
   side_type dv_in [0:DIV_STEPS];

   root_stage_type rt_ff [0:ROOT2_STEPS];
   root_stage_type rt_in;
   sqrt_type       rt_nxt [0:ROOT2_STEPS-1];
   side_type       rt_side [0:ROOT2_STEPS-1];

   logic [8:0][COORD_WIDTH-1:0] raw;

   assign adv       = !(out_ff.valid && rsp_stall);
   assign req_stall = out_ff.valid && rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid       = out_ff.valid;
   assign rsp_angle       = out_ff.angle;
   assign rsp_zero_vector = out_ff.zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_data;
      end
   end

   assign raw = {req_nz, req_ny, req_nx, req_bz, req_by_coord, req_bx, req_az, req_ay, req_ax};

   // sign and magnitude
   always_comb begin
      s1_in.valid = req_valid;
      s1_in.func  = req_func;
      for (int i = 0; i < 9; i++) begin
         s1_in.neg[i] = raw[i][COORD_WIDTH-1];
         s1_in.mag[i] = raw[i][COORD_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
      end
   end

   // zero test and prescale
   always_comb begin
      logic [SQLEN_WIDTH-1:0]   len_a;
      logic [SQLEN_WIDTH-1:0]   len_b;
      logic [2*COORD_WIDTH-1:0] sq;
      logic [COORD_WIDTH-1:0]   mx;
      logic [SHIFT_WIDTH-1:0]   sh;
      logic [MAG_EXT_WIDTH-1:0] sm;
      s2_in.valid = s1_ff.valid;
      s2_in.func  = s1_ff.func;
      len_a = '0;
      len_b = '0;
      for (int i = 0; i < 3; i++) begin
         sq    = s1_ff.mag[i] * s1_ff.mag[i];
         len_a = len_a + {2'b00, sq};
         sq    = s1_ff.mag[i+3] * s1_ff.mag[i+3];
         len_b = len_b + {2'b00, sq};
      end
      s2_in.zero = (len_a <= SQLEN_WIDTH'(limit_ff)) || (len_b <= SQLEN_WIDTH'(limit_ff));
      for (int v = 0; v < 3; v++) begin
         mx = s1_ff.mag[3*v];
         if (s1_ff.mag[3*v+1] > mx) mx = s1_ff.mag[3*v+1];
         if (s1_ff.mag[3*v+2] > mx) mx = s1_ff.mag[3*v+2];
         sh = '0;
         for (int k = COORD_WIDTH; k >= 0; k--) begin
            if ((mx >> k) < NORM_LIMIT) sh = SHIFT_WIDTH'(k);
         end
         for (int j = 0; j < 3; j++) begin
            sm = MAG_EXT_WIDTH'(s1_ff.mag[3*v+j]) >> sh;
            s2_in.pre[3*v+j] = s1_ff.neg[3*v+j] ? (~{1'b0, sm[29:0]} + 31'd1)
                                                : {1'b0, sm[29:0]};
         end
      end
   end

   // dot, lengths, cross
   always_comb begin
      logic signed [61:0] pr;
      logic signed [61:0] pq;
      s3_in.valid = s2_ff.valid;
      s3_in.func  = s2_ff.func;
      s3_in.zero  = s2_ff.zero;
      s3_in.d  = '0;
      s3_in.la = '0;
      s3_in.lb = '0;
      for (int i = 0; i < 3; i++) begin
         pr = $signed(s2_ff.pre[i]) * $signed(s2_ff.pre[i+3]);
         s3_in.d = s3_in.d + 64'(pr);
         pr = $signed(s2_ff.pre[i]) * $signed(s2_ff.pre[i]);
         s3_in.la = s3_in.la + $unsigned(pr);
         pr = $signed(s2_ff.pre[i+3]) * $signed(s2_ff.pre[i+3]);
         s3_in.lb = s3_in.lb + $unsigned(pr);
         s3_in.n[i] = s2_ff.pre[i+6];
      end
      for (int i = 0; i < 3; i++) begin
         pr = $signed(s2_ff.pre[(i+1)%3]) * $signed(s2_ff.pre[3+(i+2)%3]);
         pq = $signed(s2_ff.pre[3+(i+1)%3]) * $signed(s2_ff.pre[(i+2)%3]);
         s3_in.cr[i] = 63'(pr) - 63'(pq);
      end
   end

   // partial products of the length product and of the triple product terms
   always_comb begin
      logic signed [63:0] nd;
      logic signed [62:0] ph;
      logic signed [62:0] pl;
      s4_in.valid = s3_ff.valid;
      s4_in.func  = s3_ff.func;
      s4_in.zero  = s3_ff.zero;
      s4_in.dneg  = s3_ff.d[63];
      nd = -s3_ff.d;
      s4_in.dmag = s3_ff.d[63] ? nd[62:0] : s3_ff.d[62:0];
      s4_in.pp[0] = s3_ff.la[30:0] * s3_ff.lb[30:0];
      s4_in.pp[1] = s3_ff.la[30:0] * s3_ff.lb[61:31];
      s4_in.pp[2] = s3_ff.la[61:31] * s3_ff.lb[30:0];
      s4_in.pp[3] = s3_ff.la[61:31] * s3_ff.lb[61:31];
      for (int i = 0; i < 3; i++) begin
         ph = $signed(s3_ff.n[i]) * $signed(s3_ff.cr[i][62:31]);
         pl = $signed(s3_ff.n[i]) * $signed({1'b0, s3_ff.cr[i][30:0]});
         s4_in.tph[i] = ph;
         s4_in.tpl[i] = pl;
      end
   end

   always_comb begin
      logic signed [95:0] ts;
      logic [123:0]       pd;
      ts = '0;
      for (int i = 0; i < 3; i++) begin
         ts = ts + (96'($signed(s4_ff.tph[i])) <<< 31) + 96'($signed(s4_ff.tpl[i]));
      end
      pd = {62'b0, s4_ff.pp[0]} + ({62'b0, s4_ff.pp[1]} << 31)
         + ({62'b0, s4_ff.pp[2]} << 31) + {s4_ff.pp[3], 62'b0};
      root_in            = '0;
      root_in.side.valid = s4_ff.valid;
      root_in.side.func  = s4_ff.func;
      root_in.side.zero  = s4_ff.zero;
      root_in.side.dneg  = s4_ff.dneg;
      root_in.side.dmag  = s4_ff.dmag;
      root_in.side.flip  = ts[95];
      root_in.sq.rad     = pd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid           <= 1'b0;
         s2_ff.valid           <= 1'b0;
         s3_ff.valid           <= 1'b0;
         s4_ff.valid           <= 1'b0;
         root_ff[0].side.valid <= 1'b0;
      end else if (adv) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s4_ff      <= s4_in;
         root_ff[0] <= root_in;
      end
   end

   // sqrt of the length product
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      vau_sqrt_step u_step (
         .cur_i (root_ff[k].sq),
         .nxt_o (root_nxt[k])
      );
      always_ff @(posedge clock) begin
         if (reset) begin
            root_ff[k+1].side.valid <= 1'b0;
         end else if (adv) begin
            root_ff[k+1].side <= root_ff[k].side;
            root_ff[k+1].sq   <= root_nxt[k];
         end
      end
   end

   // restoring divide of |dot| by the root
   always_comb begin
      dv_in[0]      = root_ff[ROOT_STEPS].side;
      dv_in[0].sval = root_ff[ROOT_STEPS].sq.root;
      dv_in[0].sat  = root_ff[ROOT_STEPS].side.dmag >= {1'b0, root_ff[ROOT_STEPS].sq.root};
      dv_in[0].drem = {1'b0, root_ff[ROOT_STEPS].side.dmag};
      dv_in[0].quo  = '0;
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_comb begin
         logic [63:0] r2;
         r2       = {dv_ff[k].drem[62:0], 1'b0};
         dv_in[k+1] = dv_ff[k];
         if (r2 >= {2'b00, dv_ff[k].sval}) begin
            dv_in[k+1].drem = r2 - {2'b00, dv_ff[k].sval};
            dv_in[k+1].quo  = {dv_ff[k].quo[28:0], 1'b1};
         end else begin
            dv_in[k+1].drem = r2;
            dv_in[k+1].quo  = {dv_ff[k].quo[28:0], 1'b0};
         end
      end
   end

   for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k].valid <= 1'b0;
         end else if (adv) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // acos: sqrt(1-x) alongside the horner polynomial
   always_comb begin
      logic [30:0] xv;
      logic [30:0] om;
      xv = dv_ff[DIV_STEPS].sat ? Q_ONE : {1'b0, dv_ff[DIV_STEPS].quo};
      om = Q_ONE - xv;
      rt_in           = '0;
      rt_in.side      = dv_ff[DIV_STEPS];
      rt_in.side.xval = xv;
      rt_in.side.poly = acos_coef(3'd7);
      rt_in.sq.rad    = {1'b0, om, 30'b0, 62'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_ff[0].side.valid <= 1'b0;
      end else if (adv) begin
         rt_ff[0] <= rt_in;
      end
   end

   for (genvar k = 0; k < ROOT2_STEPS; k++) begin : g_acos
      vau_sqrt_step u_step (
         .cur_i (rt_ff[k].sq),
         .nxt_o (rt_nxt[k])
      );
      always_comb begin
         logic [35:0]        pm;
         logic [65:0]        mm;
         logic [35:0]        rq;
         logic signed [35:0] qm;
         rt_side[k] = rt_ff[k].side;
         pm = rt_ff[k].side.poly[35] ? (~rt_ff[k].side.poly + 36'd1) : rt_ff[k].side.poly;
         mm = pm[34:0] * rt_ff[k].side.xval;
         rq = mm[65:30];
         qm = rt_ff[k].side.poly[35] ? -$signed(rq) : $signed(rq);
         if (k < HORNER_STEPS) begin
            rt_side[k].poly = qm + acos_coef(3'(HORNER_STEPS - 1 - k));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rt_ff[k+1].side.valid <= 1'b0;
         end else if (adv) begin
            rt_ff[k+1].side <= rt_side[k];
            rt_ff[k+1].sq   <= rt_nxt[k];
         end
      end
   end

   always_comb begin
      logic [34:0] pc;
      logic [65:0] pr;
      pc = rt_ff[ROOT2_STEPS].side.poly[35] ? '0 : rt_ff[ROOT2_STEPS].side.poly[34:0];
      pr = pc * rt_ff[ROOT2_STEPS].sq.root[30:0];
      hh_in.valid = rt_ff[ROOT2_STEPS].side.valid;
      hh_in.func  = rt_ff[ROOT2_STEPS].side.func;
      hh_in.zero  = rt_ff[ROOT2_STEPS].side.zero;
      hh_in.flip  = rt_ff[ROOT2_STEPS].side.flip;
      hh_in.dneg  = rt_ff[ROOT2_STEPS].side.dneg;
      hh_in.theta = pr[65:30];
   end

   // cap, mode fold and rounding
   always_comb begin
      logic [32:0] th;
      logic [33:0] rnd;
      th = (hh_ff.theta > {3'b000, PI_Q}) ? PI_Q : hh_ff.theta[32:0];
      if (hh_ff.dneg) th = PI_Q - th;
      if (hh_ff.func == FUNC_ACUTE && th > HALF_PI_Q) begin
         th = PI_Q - th;
      end else if (hh_ff.func == FUNC_FULL && hh_ff.flip) begin
         th = TWO_PI_Q - th;
      end
      rnd = ({1'b0, th} + ROUND_BIAS) >> ROUND_SHIFT;
      out_in.valid = hh_ff.valid;
      out_in.zero  = hh_ff.zero;
      out_in.angle = hh_ff.zero ? '0 : rnd[ANGLE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hh_ff.valid  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         hh_ff  <= hh_in;
         out_ff <= out_in;
      end
   end

`ifndef SYNTHESIS
   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> rsp_angle == '0)
      else $error("zero vector result with nonzero angle");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled without a pending result");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle <= ANGLE_MAX)
      else $error("angle above two pi");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
